[rtl/core/lbs_pkg.sv]
`default_nettype none

package lbs_pkg;

    localparam int MAX_BONES      = 64;
    localparam int ELEMS_PER_BONE = 12;
    localparam int JOINT_BASE     = 9;
    localparam int WORD_W         = 32;
    localparam int BONE_W         = 6;
    localparam int ELEM_W         = 4;
    localparam int WEIGHT_W       = 17;
    localparam int BONE_AW        = $clog2(MAX_BONES);
    localparam int ROW_W          = ELEMS_PER_BONE * WORD_W;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // queued operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_INFL  = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    typedef struct packed {
        logic                       req_type;
        logic [BONE_W-1:0]          bone_index;
        logic [ELEM_W-1:0]          element_index;
        logic signed [WORD_W-1:0]   element_value;
        logic signed [WORD_W-1:0]   local_x;
        logic signed [WORD_W-1:0]   local_y;
        logic signed [WORD_W-1:0]   local_z;
        logic [WEIGHT_W-1:0]        weight;
        logic                       last_influence;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
    } out_t;

    typedef struct packed {
        logic [1:0]                 op;
        logic [BONE_W-1:0]          bone_index;
        logic [ELEM_W-1:0]          element_index;
        logic signed [WORD_W-1:0]   element_value;
        logic signed [WORD_W-1:0]   local_x;
        logic signed [WORD_W-1:0]   local_y;
        logic signed [WORD_W-1:0]   local_z;
        logic [WEIGHT_W-1:0]        weight;
        logic                       last_influence;
    } q_item_t;

endpackage

`default_nettype wire

[rtl/core/linear_blend_skinning.sv]
// Linear blend skinning, one bone influence per transfer.
// Request channel req/req_valid/req_ready: req_type 0 writes one element of a
// bone entry (rotation row-major, then joint x,y,z); req_type 1 adds
// weight * (joint + R * local) into the running vertex sum.
// Result channel res/res_valid/res_ready: one transfer per influence that
// carries last_influence, holding the saturated Q16.16 world position.
// A two-entry queue sits between the request decode and the execution unit.
// Execution: a write is handled by the execution unit alone; an influence reads
// one bone row, issues three rotation rows through the product/clamp/weight/
// accumulate pipeline, then drains; when it closes a vertex, the S_EMIT state
// loads the result register once it is free; the unit takes no new queue entry
// until it is back in idle.
// Reset clears the queue, the sums and the result valid flag; the bone table
// holds no defined contents until written.
// While the receiver stalls, the result register holds; the queue keeps
// taking requests until it fills, then req_ready drops.
`default_nettype none

module linear_blend_skinning (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lbs_pkg::in_t   req,
    input  wire logic           req_valid,
    output logic                req_ready,
    output lbs_pkg::out_t       res,
    output logic                res_valid,
    input  wire logic           res_ready
);
    import lbs_pkg::*;

    q_item_t q_item;
    logic    q_valid;
    logic    q_ready;

    lbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready)
    );

    lbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

endmodule

`default_nettype wire

[rtl/core/lbs_front.sv]
`default_nettype none

module lbs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lbs_pkg::in_t       req,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output lbs_pkg::q_item_t        q_item,
    output logic                    q_valid,
    input  wire logic               q_ready
);
    import lbs_pkg::*;

    q_item_t             store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    logic    bone_ok;
    logic    elem_ok;
    logic    keep;
    logic    push;
    logic    pop;
    q_item_t item_c;

    always_comb
    begin
        bone_ok = int'(req.bone_index) < MAX_BONES;
        elem_ok = int'(req.element_index) < ELEMS_PER_BONE;
        item_c.bone_index     = req.bone_index;
        item_c.element_index  = req.element_index;
        item_c.element_value  = req.element_value;
        item_c.local_x        = req.local_x;
        item_c.local_y        = req.local_y;
        item_c.local_z        = req.local_z;
        item_c.weight         = req.weight;
        item_c.last_influence = req.last_influence;
        // ignored writes and empty influences without the end mark are dropped here
        priority if (!req.req_type)
        begin
            item_c.op = OP_WRITE;
            keep      = bone_ok && elem_ok;
        end
        else if (bone_ok)
        begin
            item_c.op = OP_INFL;
            keep      = 1'b1;
        end
        else
        begin
            item_c.op = OP_EMIT;
            keep      = req.last_influence;
        end
    end

    assign req_ready = count_reg != QCNT_W'(QDEPTH);
    assign push      = req_valid && req_ready && keep;
    assign q_valid   = count_reg != '0;
    assign pop       = q_valid && q_ready;
    assign q_item    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= item_c;
        end
    end

endmodule

`default_nettype wire

[rtl/core/lbs_back.sv]
`default_nettype none

module lbs_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lbs_pkg::q_item_t   q_item,
    input  wire logic               q_valid,
    output logic                    q_ready,
    output lbs_pkg::out_t           res,
    output logic                    res_valid,
    input  wire logic               res_ready
);
    import lbs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic signed [49:0] T_MAX = 50'sh0_7FFF_FFFF;
    localparam logic signed [49:0] T_MIN = -50'sh0_8000_0000;
    localparam logic signed [47:0] O_MAX = 48'sh7FFF_FFFF;
    localparam logic signed [47:0] O_MIN = -48'sh8000_0000;

    function automatic logic signed [WORD_W-1:0] sat_out(input logic signed [63:0] s);
        logic signed [47:0] f;
        f = s[63:16];
        if (f > O_MAX)
        begin
            return O_MAX[WORD_W-1:0];
        end
        else if (f < O_MIN)
        begin
            return O_MIN[WORD_W-1:0];
        end
        return f[WORD_W-1:0];
    endfunction

    logic [ROW_W-1:0]  mem [MAX_BONES];
    logic [ROW_W-1:0]  rd_row_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [1:0]        issue_reg;
    q_item_t           cur_reg;

    logic              a_v_reg;
    logic [1:0]        a_row_reg;
    logic signed [63:0] p0_reg;
    logic signed [63:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic signed [WORD_W-1:0] joint_reg;

    logic              b_v_reg;
    logic [1:0]        b_row_reg;
    logic signed [WORD_W-1:0] t_reg;

    logic              c_v_reg;
    logic [1:0]        c_row_reg;
    logic signed [49:0] wp_reg;

    logic signed [63:0] sum_reg [3];
    logic              res_valid_reg;
    out_t              res_reg;

    logic              pop;
    logic              issue;
    logic              emit;
    logic [3:0]        k0;
    logic [3:0]        kj;
    logic signed [WORD_W-1:0] r0;
    logic signed [WORD_W-1:0] r1;
    logic signed [WORD_W-1:0] r2;
    logic signed [WORD_W-1:0] jnt;
    logic signed [63:0] p0_c;
    logic signed [63:0] p1_c;
    logic signed [63:0] p2_c;
    logic signed [49:0] acc_c;
    logic signed [WORD_W-1:0] t_c;
    logic signed [49:0] wp_c;
    logic signed [64:0] s_c;
    logic signed [63:0] sum_new;

    assign q_ready   = state_reg == S_IDLE;
    assign pop       = q_valid && q_ready;
    assign issue     = state_reg == S_CALC && issue_reg != 2'd3;
    assign emit      = state_reg == S_EMIT && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        k0  = 4'(issue_reg) * 4'd3;
        kj  = 4'(JOINT_BASE) + 4'(issue_reg);
        r0  = rd_row_reg[WORD_W*k0 +: WORD_W];
        r1  = rd_row_reg[WORD_W*(k0 + 4'd1) +: WORD_W];
        r2  = rd_row_reg[WORD_W*(k0 + 4'd2) +: WORD_W];
        jnt = rd_row_reg[WORD_W*kj +: WORD_W];
        p0_c = r0 * cur_reg.local_x;
        p1_c = r1 * cur_reg.local_y;
        p2_c = r2 * cur_reg.local_z;

        // floor to Q16.16, add joint, clamp to 32 bits
        acc_c = 50'(joint_reg) + 50'(p0_reg >>> 16) + 50'(p1_reg >>> 16)
              + 50'(p2_reg >>> 16);
        if (acc_c > T_MAX)
        begin
            t_c = T_MAX[WORD_W-1:0];
        end
        else if (acc_c < T_MIN)
        begin
            t_c = T_MIN[WORD_W-1:0];
        end
        else
        begin
            t_c = acc_c[WORD_W-1:0];
        end

        wp_c = 50'(t_reg) * 50'($signed({1'b0, cur_reg.weight}));

        s_c = 65'(sum_reg[c_row_reg]) + 65'(wp_reg);
        if (s_c[64] != s_c[63])
        begin
            sum_new = s_c[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            sum_new = s_c[63:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && q_item.op == OP_INFL)
                begin
                    state_next = S_CALC;
                end
                else if (pop && q_item.op == OP_EMIT)
                begin
                    state_next = S_EMIT;
                end
            end
            S_CALC:
            begin
                if (issue_reg == 2'd3 && !a_v_reg && !b_v_reg && !c_v_reg)
                begin
                    state_next = cur_reg.last_influence ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= 2'd0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            sum_reg[0]    <= '0;
            sum_reg[1]    <= '0;
            sum_reg[2]    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                issue_reg <= 2'd0;
            end
            else if (issue)
            begin
                issue_reg <= issue_reg + 2'd1;
            end
            a_v_reg <= issue;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            if (c_v_reg)
            begin
                sum_reg[c_row_reg] <= sum_new;
            end
            if (emit)
            begin
                sum_reg[0]    <= '0;
                sum_reg[1]    <= '0;
                sum_reg[2]    <= '0;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // the bone row is captured once per transfer and held while its rows are issued
    always_ff @(posedge clk)
    begin
        if (pop && q_item.op == OP_WRITE)
        begin
            mem[q_item.bone_index[BONE_AW-1:0]][WORD_W*q_item.element_index +: WORD_W]
                <= q_item.element_value;
        end
        if (pop)
        begin
            rd_row_reg <= mem[q_item.bone_index[BONE_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_item;
        end
        a_row_reg <= issue_reg;
        p0_reg    <= p0_c;
        p1_reg    <= p1_c;
        p2_reg    <= p2_c;
        joint_reg <= jnt;
        b_row_reg <= a_row_reg;
        t_reg     <= t_c;
        c_row_reg <= b_row_reg;
        wp_reg    <= wp_c;
        if (emit)
        begin
            res_reg.pos_x <= sat_out(sum_reg[0]);
            res_reg.pos_y <= sat_out(sum_reg[1]);
            res_reg.pos_z <= sat_out(sum_reg[2]);
        end
    end

endmodule

`default_nettype wire
